[sv/ffp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flame and firefly PWM driver package
// Shared constants, firefly phase codes, and the command and status words
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ffp_pkg;

    localparam int LEVEL_W    = 16;
    localparam int TIME_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int DRAWS_W    = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DRAWS_W;

    localparam logic [15:0] LFSR_TAPS   = 16'h822B;
    localparam logic [15:0] LFSR_SEED   = 16'h55CE;
    localparam logic [15:0] LEVEL_RESET = 16'hFFFF;
    localparam logic [7:0]  DRAW_LIMIT  = 8'd128;
    localparam logic [7:0]  DUTY_STEP   = 8'd8;
    localparam logic [7:0]  HOLD_STEP   = 8'd4;
    localparam logic [7:0]  OFF0_RESET  = 8'd2;
    localparam logic [7:0]  OFF1_RESET  = 8'd3;
    localparam logic [DRAWS_W-1:0] DRAWS_A_RESET = 3'd3;
    localparam logic [DRAWS_W-1:0] DRAWS_B_RESET = 3'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DRAWS_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAWS_B = 1'b1;

    typedef enum logic [1:0] {
        PH_OFF  = 2'd0,
        PH_RISE = 2'd1,
        PH_HOLD = 2'd2,
        PH_FALL = 2'd3
    } t_phase;

    typedef struct packed {
        logic capture;    // latch the accepted word
        logic flick;      // run one level filter
        logic flick_sel;  // 0 flame A, 1 flame B
        logic draw;       // advance the LFSR once
        logic flame_pwm;  // step both flame PWM counters
        logic fly_step;   // step one firefly
        logic fly_sel;    // which firefly
        logic load_out;   // copy the state into the output register
    } t_cmd;

    typedef struct packed {
        logic draw_big;   // the LFSR low byte after the next advance exceeds the limit
    } t_status;

endpackage

[sv/ffp_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flame and firefly PWM driver input channel
// Carries one tick word: its kind and the current slow time.
// ----------------------------------------------------------------------------
interface ffp_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] now_time;

    modport source (output valid, output mode, output now_time, input ready);
    modport sink   (input valid, input mode, input now_time, output ready);
endinterface

[sv/ffp_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flame and firefly PWM driver output channel
// Carries the LED levels, firefly phases and flame levels after each tick.
// ----------------------------------------------------------------------------
interface ffp_out_if;
    logic        valid;
    logic        ready;
    logic        flame_a_on;
    logic        flame_b_on;
    logic        fly0_on;
    logic        fly1_on;
    logic [1:0]  fly0_phase;
    logic [1:0]  fly1_phase;
    logic [15:0] level_a;
    logic [15:0] level_b;

    modport source (output valid, output flame_a_on, output flame_b_on, output fly0_on,
                    output fly1_on, output fly0_phase, output fly1_phase,
                    output level_a, output level_b, input ready);
    modport sink   (input valid, input flame_a_on, input flame_b_on, input fly0_on,
                    input fly1_on, input fly0_phase, input fly1_phase,
                    input level_a, input level_b, output ready);
endinterface

[sv/flame_flicker_firefly_pwm_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flame and firefly PWM driver
// Drives two flickering flame LEDs and two fading fireflies from tick words.
// ----------------------------------------------------------------------------
// One word at a time is processed. On a PWM tick the flame counters and the
// first firefly step in the S_PWM state and the second firefly in S_FLY1,
// since a single firefly step unit is shared. A flicker tick runs each level
// filter and then advances the LFSR once per draw, up to seven times per
// filter, and a run may end early on a large low byte. The result sits in an
// output register, so the next word is taken while a result waits.

module flame_flicker_firefly_pwm_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ffp_in_if.sink                          i_in,
    ffp_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [ffp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ffp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    ffp_pkg::t_cmd    w_cmd;
    ffp_pkg::t_status w_status;

    ffp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    ffp_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_now_time   (i_in.now_time),
        .o_flame_a_on (o_out.flame_a_on),
        .o_flame_b_on (o_out.flame_b_on),
        .o_fly0_on    (o_out.fly0_on),
        .o_fly1_on    (o_out.fly1_on),
        .o_fly0_phase (o_out.fly0_phase),
        .o_fly1_phase (o_out.fly1_phase),
        .o_level_a    (o_out.level_a),
        .o_level_b    (o_out.level_b)
    );

    // A word in progress closes the input until its result is registered.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken again while a word is in progress");

    // A new result appears only when the controller loaded the output register.
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_cmd.load_out))
        else $error("output valid rose without a load");

    // At most one of filter, draw, firefly step and output load is commanded per cycle.
    a_single_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.flick, w_cmd.draw, w_cmd.fly_step, w_cmd.load_out}))
        else $error("conflicting datapath commands");

endmodule

[sv/ffp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flame and firefly PWM driver controller
// Sequences the filter updates, LFSR advances and PWM steps of one word,
// holds the draw-count registers and the output valid flag.
// ----------------------------------------------------------------------------
module ffp_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_mode,
    output logic                             o_in_ready,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    input  logic                             i_cfg_we,
    input  logic [ffp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ffp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  ffp_pkg::t_status                 i_status,
    output ffp_pkg::t_cmd                    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FLICK_A,
        S_DRAW_A,
        S_FLICK_B,
        S_DRAW_B,
        S_PWM,
        S_FLY1,
        S_DONE
    } t_state;

    t_state                            r_state, n_state;
    logic [ffp_pkg::DRAWS_W-1:0]       r_cnt, n_cnt;
    logic [ffp_pkg::DRAWS_W-1:0]       r_draws_a, n_draws_a;
    logic [ffp_pkg::DRAWS_W-1:0]       r_draws_b, n_draws_b;
    logic                              r_out_valid, n_out_valid;
    logic                              w_accept;
    logic                              w_out_free;
    logic [ffp_pkg::DRAWS_W-1:0]       w_cnt_inc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_cnt_inc   = r_cnt + 1'b1;

    always_comb begin
        o_cmd           = '0;
        o_cmd.capture   = w_accept;
        o_cmd.flick     = (r_state == S_FLICK_A) || (r_state == S_FLICK_B);
        o_cmd.flick_sel = (r_state == S_FLICK_B);
        o_cmd.draw      = (r_state == S_DRAW_A) || (r_state == S_DRAW_B);
        o_cmd.flame_pwm = (r_state == S_PWM);
        o_cmd.fly_step  = (r_state == S_PWM) || (r_state == S_FLY1);
        o_cmd.fly_sel   = (r_state == S_FLY1);
        o_cmd.load_out  = (r_state == S_DONE) && w_out_free;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_draws_a   = r_draws_a;
        n_draws_b   = r_draws_b;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = i_in_mode ? S_FLICK_A : S_PWM;
                end
            end
            S_FLICK_A: begin
                n_cnt   = '0;
                n_state = (r_draws_a == '0) ? S_FLICK_B : S_DRAW_A;
            end
            S_DRAW_A: begin
                // Each advance may end the run early on a large low byte.
                if (w_cnt_inc == r_draws_a || i_status.draw_big) begin
                    n_state = S_FLICK_B;
                end else begin
                    n_cnt = w_cnt_inc;
                end
            end
            S_FLICK_B: begin
                n_cnt   = '0;
                n_state = (r_draws_b == '0) ? S_DONE : S_DRAW_B;
            end
            S_DRAW_B: begin
                if (w_cnt_inc == r_draws_b || i_status.draw_big) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = w_cnt_inc;
                end
            end
            S_PWM: begin
                n_state = S_FLY1;
            end
            S_FLY1: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                ffp_pkg::CFG_DRAWS_A: n_draws_a = i_cfg_data;
                ffp_pkg::CFG_DRAWS_B: n_draws_b = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_draws_a   <= ffp_pkg::DRAWS_A_RESET;
            r_draws_b   <= ffp_pkg::DRAWS_B_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_draws_a   <= n_draws_a;
            r_draws_b   <= n_draws_b;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[sv/ffp_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flame and firefly PWM driver datapath
// Holds the LFSR, flame filters, PWM counters, firefly state and the output
// register, and carries out the controller commands of each cycle.
// ----------------------------------------------------------------------------
module ffp_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ffp_pkg::t_cmd                 i_cmd,
    output ffp_pkg::t_status              o_status,
    input  logic [ffp_pkg::TIME_W-1:0]    i_now_time,
    output logic                          o_flame_a_on,
    output logic                          o_flame_b_on,
    output logic                          o_fly0_on,
    output logic                          o_fly1_on,
    output logic [1:0]                    o_fly0_phase,
    output logic [1:0]                    o_fly1_phase,
    output logic [ffp_pkg::LEVEL_W-1:0]   o_level_a,
    output logic [ffp_pkg::LEVEL_W-1:0]   o_level_b
);

    localparam int BW = ffp_pkg::BYTE_W;
    localparam int LW = ffp_pkg::LEVEL_W;
    localparam int TW = ffp_pkg::TIME_W;

    logic [LW-1:0]        r_lfsr;
    logic [LW-1:0]        r_level   [2];
    logic [BW-1:0]        r_flame_cnt [2];
    ffp_pkg::t_phase      r_phase   [2];
    logic [TW-1:0]        r_start   [2];
    logic [BW-1:0]        r_off     [2];
    logic [BW-1:0]        r_duty    [2];
    logic [BW-1:0]        r_fcnt    [2];
    logic [3:0]           r_led;
    logic [TW-1:0]        r_now;

    // Output register.
    logic [3:0]           r_o_led;
    ffp_pkg::t_phase      r_o_phase [2];
    logic [LW-1:0]        r_o_level [2];

    logic [LW-1:0]        w_lfsr_next;
    logic [LW-1:0]        w_old;
    logic [LW-1:0]        w_level_new;
    logic [3:0]           n_led;
    logic [1:0]           w_fly_bit;

    ffp_pkg::t_phase      w_ph;
    logic [BW-1:0]        w_duty;
    logic [BW-1:0]        w_cnt;
    logic [TW-1:0]        w_diff;
    ffp_pkg::t_phase      n_ph;
    logic [BW-1:0]        n_duty;
    logic [BW-1:0]        n_cnt;
    logic [TW-1:0]        n_start;
    logic [BW-1:0]        n_off_sel;
    logic [BW-1:0]        n_off0;
    logic [BW-1:0]        n_off1;
    logic                 n_fly_led;

    assign w_lfsr_next = r_lfsr[0] ? ((r_lfsr >> 1) ^ ffp_pkg::LFSR_TAPS) : (r_lfsr >> 1);
    assign o_status.draw_big = (w_lfsr_next[BW-1:0] > ffp_pkg::DRAW_LIMIT);

    // Filter: new = old - old/2 + byte * 128, kept to 16 bits.
    assign w_old       = r_level[i_cmd.flick_sel];
    assign w_level_new = w_old - (w_old >> 1) + {1'b0, r_lfsr[BW-1:0], 7'b0};

    assign w_fly_bit = {1'b1, i_cmd.fly_sel};

    // One firefly step for the selected firefly.
    always_comb begin
        w_ph      = r_phase[i_cmd.fly_sel];
        w_duty    = r_duty[i_cmd.fly_sel];
        w_cnt     = r_fcnt[i_cmd.fly_sel];
        w_diff    = r_now - r_start[i_cmd.fly_sel];
        n_ph      = w_ph;
        n_duty    = w_duty;
        n_cnt     = w_cnt;
        n_start   = r_start[i_cmd.fly_sel];
        n_off_sel = r_off[i_cmd.fly_sel];
        n_fly_led = r_led[w_fly_bit];

        case (w_ph)
            ffp_pkg::PH_OFF: begin
                if (w_diff > {{(TW-BW){1'b0}}, n_off_sel}) begin
                    n_ph   = ffp_pkg::PH_RISE;
                    n_duty = '0;
                    n_cnt  = '0;
                end
            end
            ffp_pkg::PH_RISE: begin
                if (w_cnt > w_duty) begin
                    n_fly_led = 1'b0;
                end else if (w_cnt == '0) begin
                    n_fly_led = 1'b1;
                    n_duty    = w_duty + ffp_pkg::DUTY_STEP;
                end
                n_cnt = w_cnt + 1'b1;
                // Rising ends when the duty wraps round to zero.
                if (n_duty == '0) begin
                    n_ph    = ffp_pkg::PH_HOLD;
                    n_start = r_now;
                    n_cnt   = '0;
                end
            end
            ffp_pkg::PH_HOLD: begin
                n_cnt = w_cnt + ffp_pkg::HOLD_STEP;
                if (n_cnt == '0) begin
                    n_ph = ffp_pkg::PH_FALL;
                end
            end
            default: begin
                if (w_cnt > w_duty) begin
                    n_fly_led = 1'b0;
                end else if (w_cnt == '0) begin
                    n_fly_led = 1'b1;
                    n_duty    = w_duty - ffp_pkg::DUTY_STEP;
                end
                n_cnt = w_cnt + 1'b1;
                if (n_duty == '0) begin
                    n_fly_led = 1'b0;
                    n_ph      = ffp_pkg::PH_OFF;
                    n_start   = r_now;
                    n_off_sel = {{(BW-3){1'b0}}, r_lfsr[2:0]} + 1'b1;
                end
            end
        endcase

        // The two off times are kept apart by nudging the first one.
        n_off0 = i_cmd.fly_sel ? r_off[0] : n_off_sel;
        n_off1 = i_cmd.fly_sel ? n_off_sel : r_off[1];
        if (n_off0 == n_off1) begin
            n_off0 = n_off0 + 1'b1;
        end
    end

    always_comb begin
        n_led = r_led;
        if (i_cmd.flame_pwm) begin
            for (int k = 0; k < 2; k++) begin
                if (r_flame_cnt[k] > r_level[k][LW-1:BW]) begin
                    n_led[k] = 1'b0;
                end else if (r_flame_cnt[k] == '0) begin
                    n_led[k] = 1'b1;
                end
            end
        end
        if (i_cmd.fly_step) begin
            n_led[w_fly_bit] = n_fly_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= ffp_pkg::LFSR_SEED;
            r_led  <= '0;
            for (int k = 0; k < 2; k++) begin
                r_level[k]     <= ffp_pkg::LEVEL_RESET;
                r_flame_cnt[k] <= '0;
                r_phase[k]     <= ffp_pkg::PH_OFF;
                r_start[k]     <= '0;
                r_duty[k]      <= '0;
                r_fcnt[k]      <= '0;
            end
            r_off[0] <= ffp_pkg::OFF0_RESET;
            r_off[1] <= ffp_pkg::OFF1_RESET;
        end else begin
            r_led <= n_led;
            if (i_cmd.draw) begin
                r_lfsr <= w_lfsr_next;
            end
            if (i_cmd.flick) begin
                r_level[i_cmd.flick_sel] <= w_level_new;
            end
            if (i_cmd.flame_pwm) begin
                for (int k = 0; k < 2; k++) begin
                    r_flame_cnt[k] <= r_flame_cnt[k] + 1'b1;
                end
            end
            if (i_cmd.fly_step) begin
                r_phase[i_cmd.fly_sel] <= n_ph;
                r_duty[i_cmd.fly_sel]  <= n_duty;
                r_fcnt[i_cmd.fly_sel]  <= n_cnt;
                r_start[i_cmd.fly_sel] <= n_start;
                r_off[0]               <= n_off0;
                r_off[1]               <= n_off1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now <= i_now_time;
        end
        if (i_cmd.load_out) begin
            r_o_led      <= r_led;
            r_o_phase[0] <= r_phase[0];
            r_o_phase[1] <= r_phase[1];
            r_o_level[0] <= r_level[0];
            r_o_level[1] <= r_level[1];
        end
    end

    assign o_flame_a_on = r_o_led[0];
    assign o_flame_b_on = r_o_led[1];
    assign o_fly0_on    = r_o_led[2];
    assign o_fly1_on    = r_o_led[3];
    assign o_fly0_phase = r_o_phase[0];
    assign o_fly1_phase = r_o_phase[1];
    assign o_level_a    = r_o_level[0];
    assign o_level_b    = r_o_level[1];

endmodule
